>>> design/gemtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gemtc_pkg
// Shared types and constants for the gated EMA trend classifier.
// ----------------------------------------------------------------------------
package gemtc_pkg;

    localparam int unsigned DATA_W  = 24;   // Q8.16 pressure
    localparam int unsigned BETA_W  = 16;   // Q0.16 weight
    localparam int unsigned FC_W    = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Q1.16 "one" of the weight (1.00 - beta)
    localparam logic [BETA_W:0] ONE_Q16 = 17'h10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BETA            = 3'd4;

    // reset values
    localparam logic [DATA_W-1:0] RANGE_LOW_RST       = 24'd1683620;
    localparam logic [DATA_W-1:0] RANGE_HIGH_RST      = 24'd2101084;
    localparam logic [DATA_W-1:0] UPPER_THRESHOLD_RST = 24'd1979187;
    localparam logic [DATA_W-1:0] LOWER_THRESHOLD_RST = 24'd1952973;
    localparam logic [BETA_W-1:0] BETA_RST            = 16'd32768;

    typedef enum logic [FC_W-1:0] {
        FC_INVALID      = 3'd0,
        FC_RESTART      = 3'd1,
        FC_FAIR         = 3'd2,
        FC_CLOUDY       = 3'd3,
        FC_CLEARING     = 3'd4,
        FC_STORM        = 3'd5,
        FC_NO_CHANGE    = 3'd6,
        FC_PRECIP_LIKELY = 3'd7
    } forecast_t;

    typedef struct packed {
        logic [DATA_W-1:0] range_low;
        logic [DATA_W-1:0] range_high;
        logic [DATA_W-1:0] upper_threshold;
        logic [DATA_W-1:0] lower_threshold;
        logic [BETA_W-1:0] beta;
    } cfg_t;

    typedef struct packed {
        logic              sample_valid;
        logic [DATA_W-1:0] filtered;
        forecast_t         forecast;
    } result_t;

    // filter state carried from one word to the next
    typedef struct packed {
        logic [DATA_W-1:0] prev_filtered;
        logic              in_run;
    } trend_state_t;

endpackage : gemtc_pkg
`default_nettype wire

>>> design/gemtc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gemtc_ifs
// Valid/ready stream interfaces for sample words and result words.
// ----------------------------------------------------------------------------
interface gemtc_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface : gemtc_in_if

interface gemtc_out_if;
    logic        valid;
    logic        ready;
    logic        sample_valid;
    logic [23:0] filtered;
    logic [2:0]  forecast;

    modport source (output valid, output sample_valid, output filtered,
                    output forecast, input ready);
    modport sink   (input valid, input sample_valid, input filtered,
                    input forecast, output ready);
endinterface : gemtc_out_if
`default_nettype wire

>>> design/gemtc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gemtc_cfg_regs
// Write-only configuration register file.
// ----------------------------------------------------------------------------
module gemtc_cfg_regs
    import gemtc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low       <= RANGE_LOW_RST;
            cfg_reg.range_high      <= RANGE_HIGH_RST;
            cfg_reg.upper_threshold <= UPPER_THRESHOLD_RST;
            cfg_reg.lower_threshold <= LOWER_THRESHOLD_RST;
            cfg_reg.beta            <= BETA_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_LOW:       cfg_reg.range_low       <= cfg_data[DATA_W-1:0];
                REG_RANGE_HIGH:      cfg_reg.range_high      <= cfg_data[DATA_W-1:0];
                REG_UPPER_THRESHOLD: cfg_reg.upper_threshold <= cfg_data[DATA_W-1:0];
                REG_LOWER_THRESHOLD: cfg_reg.lower_threshold <= cfg_data[DATA_W-1:0];
                REG_BETA:            cfg_reg.beta            <= cfg_data[BETA_W-1:0];
                default:             ;  // unmapped index, ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : gemtc_cfg_regs
`default_nettype wire

>>> design/gemtc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gemtc_datapath
// Range gate, EMA update and trend classing for one sample word.
// ----------------------------------------------------------------------------
module gemtc_datapath
    import gemtc_pkg::*;
(
    input  wire cfg_t               cfg,
    input  wire logic [DATA_W-1:0]  sample,
    input  wire trend_state_t       state,
    output result_t                 result,
    output trend_state_t            state_next
);

    logic                       in_range;
    logic [BETA_W:0]            one_minus_beta;
    logic [DATA_W+BETA_W-1:0]   new_term;     // beta * x
    logic [DATA_W+BETA_W:0]     old_term;     // (1-beta) * prev
    logic [DATA_W+BETA_W:0]     acc;
    logic [DATA_W-1:0]          ema;
    logic                       rising;
    forecast_t                  trend_code;

    always_comb
    begin
        in_range       = (sample >= cfg.range_low) && (sample <= cfg.range_high);
        one_minus_beta = ONE_Q16 - {1'b0, cfg.beta};
        new_term       = cfg.beta * sample;
        old_term       = one_minus_beta * state.prev_filtered;
        // sum stays below 2^40, so the extra top bit never sets
        acc            = {1'b0, new_term} + old_term;
        ema            = acc[DATA_W+BETA_W-1:BETA_W];
        rising         = (ema >= state.prev_filtered);

        // high test first: crossed thresholds never reach the middle band
        priority if (ema > cfg.upper_threshold)
            trend_code = rising ? FC_FAIR : FC_CLOUDY;
        else if (ema < cfg.lower_threshold)
            trend_code = rising ? FC_CLEARING : FC_STORM;
        else
            trend_code = rising ? FC_NO_CHANGE : FC_PRECIP_LIKELY;

        state_next = state;
        if (!in_range)
        begin
            result.sample_valid = 1'b0;
            result.filtered     = '0;
            result.forecast     = FC_INVALID;
            state_next.in_run   = 1'b0;
        end
        else if (!state.in_run)
        begin
            result.sample_valid      = 1'b1;
            result.filtered          = sample;
            result.forecast          = FC_RESTART;
            state_next.in_run        = 1'b1;
            state_next.prev_filtered = sample;
        end
        else
        begin
            result.sample_valid      = 1'b1;
            result.filtered          = ema;
            result.forecast          = trend_code;
            state_next.prev_filtered = ema;
        end
    end

endmodule : gemtc_datapath
`default_nettype wire

>>> design/gated_ema_trend_classifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gated_ema_trend_classifier_unit
// Pressure trend classifier built on a gated first-order EMA filter.
// ----------------------------------------------------------------------------
// Takes one Q8.16 pressure sample per input word and returns exactly one
// result word per sample, in order. A sample inside [range_low, range_high]
// is valid; the first valid sample of a run seeds the filter and reports
// restart, later ones are filtered as (beta*x + (1-beta)*prev) >> 16 and
// classed by band (upper/lower thresholds, inclusive middle band) and by
// rise/fall against the previous filtered value. An invalid sample reports
// zeros and ends the run. Throughput is one word per clock unless the output
// stalls: the sample is registered, the filter multiply-add and compares
// work combinationally on it and land in the output register, which also
// updates the filter state, so the next sample always sees the fresh
// previous value, and raises output valid. The output register decouples
// the two sides: the input keeps flowing while a result waits, stalling
// only when both stages hold a word and the output is not ready. Config is
// write-only and should be changed only with the block empty.
// ----------------------------------------------------------------------------
module gated_ema_trend_classifier_unit
    import gemtc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    gemtc_in_if.sink                   in_ch,
    gemtc_out_if.source                out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t          cfg;

    // input stage
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_sample_reg;

    // output stage
    logic              out_valid_reg;
    result_t           out_word_reg;

    // filter state
    trend_state_t      state_reg;
    trend_state_t      state_next;
    result_t           result;

    logic              advance;     // input stage moves into output stage
    logic              in_take;

    gemtc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gemtc_datapath u_dp (
        .cfg        (cfg),
        .sample     (in_sample_reg),
        .state      (state_reg),
        .result     (result),
        .state_next (state_next)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_sample_reg <= in_ch.sample;
        if (advance)
            out_word_reg <= result;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sample_valid = out_word_reg.sample_valid;
    assign out_ch.filtered     = out_word_reg.filtered;
    assign out_ch.forecast     = out_word_reg.forecast;

endmodule : gated_ema_trend_classifier_unit
`default_nettype wire
